>>> src/wfta_pkg.sv
// shared types and constants for the windowed frame time average block
package wfta_pkg;

    // field widths of the stream items
    localparam int SAMPLE_W    = 16;
    localparam int TENTHS_W    = 20;
    localparam int WHOLE_W     = 16;
    localparam int DIGIT_W     = 4;
    localparam int FILL_W      = 5;
    localparam int OUT_TDATA_W = 48;

    // clamp ceiling after reset
    localparam logic [SAMPLE_W-1:0] MAX_SAMPLE_RST = 16'd100;

    // divide by ten through a reciprocal, exact for values below 2**22
    localparam int                  RECIP_SHIFT = 23;
    localparam logic [TENTHS_W-1:0] RECIP_10    = 20'd838861;
    localparam logic [DIGIT_W-1:0]  DIGIT_LIMIT = 4'd10;

    // one classified item between front and back
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                restart;
    } t_item;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

endpackage

>>> src/wfta_front.sv
// front end: ceiling register, input beat acceptance and clamping
module wfta_front
    import wfta_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [SAMPLE_W-1:0] i_cfg_data,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [SAMPLE_W-1:0] i_s_tdata,
    input  logic                i_s_tuser,
    output logic                o_push,
    output t_item               o_item,
    input  t_queue_stat         i_stat
);

    logic [SAMPLE_W-1:0] r_max_sample;

    // ceiling register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_sample <= MAX_SAMPLE_RST;
        end else if (i_cfg_valid) begin
            r_max_sample <= i_cfg_data;
        end
    end

    // accept while the queue has room
    assign o_s_tready = !i_stat.full;
    assign o_push     = i_s_tvalid && !i_stat.full;

    // clamp the frame time to the ceiling
    always_comb begin
        o_item.restart = i_s_tuser;
        o_item.sample  = (i_s_tdata > r_max_sample) ? r_max_sample : i_s_tdata;
    end

endmodule

>>> src/wfta_queue.sv
// two entry queue between front and back
module wfta_queue
    import wfta_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_item       i_item,
    input  logic        i_pop,
    output t_item       o_item,
    output t_queue_stat o_stat
);

    t_item       r_mem [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    // pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_item       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

    // occupancy never passes the depth
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("queue occupancy out of range");

    // push only with room, pop only with data
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push |-> !o_stat.full) and (i_pop |-> !o_stat.empty))
        else $error("queue overflow or underflow");

endmodule

>>> src/wfta_back.sv
// back end: window ring, running sum, serial divider and digit split
module wfta_back
    import wfta_pkg::*;
#(
    parameter int WINDOW = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_item                  i_item,
    input  t_queue_stat            i_stat,
    output logic                   o_pop,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
    localparam int DIV_W  = SUM_W + 4;
    localparam int STEP_W = $clog2(DIV_W);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_UPD   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_QUOT  = 3'd4;
    localparam logic [2:0] S_DIGIT = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]          r_state;
    logic [2:0]          n_state;
    logic [IDX_W-1:0]    r_idx;
    logic [CNT_W-1:0]    r_cnt;
    logic [SUM_W-1:0]    r_sum;
    logic [SAMPLE_W-1:0] r_sample;
    logic [SAMPLE_W-1:0] r_ring [WINDOW];
    logic [SAMPLE_W-1:0] r_rd;
    logic [CNT_W-1:0]    r_rem;
    logic [DIV_W-1:0]    r_quo;
    logic [STEP_W-1:0]   r_step;
    logic [TENTHS_W-1:0] r_tenths;
    logic [WHOLE_W-1:0]  r_whole;
    logic [DIGIT_W-1:0]  r_digit;
    logic                r_m_tvalid;

    logic                  w_full;
    logic [SAMPLE_W-1:0]   w_old;
    logic [SUM_W-1:0]      w_sum;
    logic [DIV_W-1:0]      w_dividend;
    logic [CNT_W:0]        w_trial;
    logic [CNT_W:0]        w_diff;
    logic                  w_ge;
    logic [2*TENTHS_W-1:0] w_prod;
    logic [TENTHS_W-1:0]   w_whole_x10;
    logic [TENTHS_W-1:0]   w_rest;

    // window ring, one write in the update state and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (r_state == S_UPD) begin
            r_ring[r_idx] <= r_sample;
        end
        r_rd <= r_ring[r_idx];
    end

    // slots past the fill count were never written since the last clear
    assign w_full = (r_cnt == CNT_W'(WINDOW));
    assign w_old  = w_full ? r_rd : '0;
    assign w_sum  = r_sum - SUM_W'(w_old) + SUM_W'(r_sample);
    assign w_dividend = DIV_W'({w_sum, 3'b000}) + DIV_W'({w_sum, 1'b0});

    // restoring divide step, one quotient bit per cycle
    assign w_trial = {r_rem, r_quo[DIV_W-1]};
    assign w_diff  = w_trial - {1'b0, r_cnt};
    assign w_ge    = (w_trial >= {1'b0, r_cnt});

    // whole ms by reciprocal, tenth digit by remainder
    assign w_prod      = r_quo[TENTHS_W-1:0] * RECIP_10;
    assign w_whole_x10 = TENTHS_W'({r_whole, 3'b000}) + TENTHS_W'({r_whole, 1'b0});
    assign w_rest      = r_tenths - w_whole_x10;

    assign o_pop = (r_state == S_IDLE) && !i_stat.empty;

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (!i_stat.empty) n_state = S_READ;
            S_READ:  n_state = S_UPD;
            S_UPD:   n_state = S_DIV;
            S_DIV:   if (r_step == '0) n_state = S_QUOT;
            S_QUOT:  n_state = S_DIGIT;
            S_DIGIT: n_state = S_OUT;
            S_OUT:   if (i_m_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= '0;
            r_cnt      <= '0;
            r_sum      <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop && i_item.restart) begin
                r_idx <= '0;
                r_cnt <= '0;
                r_sum <= '0;
            end
            if (r_state == S_UPD) begin
                r_sum <= w_sum;
                r_idx <= (r_idx == IDX_W'(WINDOW - 1)) ? '0 : r_idx + 1'b1;
                if (!w_full) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (r_state == S_DIGIT) begin
                r_m_tvalid <= 1'b1;
            end else if (r_state == S_OUT && i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_sample <= i_item.sample;
            end
            S_UPD: begin
                r_quo  <= w_dividend;
                r_rem  <= '0;
                r_step <= STEP_W'(DIV_W - 1);
            end
            S_DIV: begin
                r_rem  <= w_ge ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
                r_quo  <= {r_quo[DIV_W-2:0], w_ge};
                r_step <= r_step - 1'b1;
            end
            S_QUOT: begin
                r_tenths <= r_quo[TENTHS_W-1:0];
                r_whole  <= w_prod[RECIP_SHIFT +: WHOLE_W];
            end
            S_DIGIT: begin
                r_digit <= w_rest[DIGIT_W-1:0];
            end
            default: begin
                r_sample <= r_sample;
            end
        endcase
    end

    // result beat
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = {3'b000, FILL_W'(r_cnt), r_digit, r_whole, r_tenths};

    // fill count never passes the window size
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(WINDOW))
        else $error("fill count above window size");

    // divider runs with a nonzero divisor and a reduced remainder
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt != '0) && (r_rem < r_cnt))
        else $error("divider remainder not below fill count");

    // a shown result has a decimal tenth digit
    a_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_digit < DIGIT_LIMIT) && (r_state == S_OUT))
        else $error("bad tenth digit or stray result valid");

endmodule

>>> src/windowed_frame_time_average.sv
// top level of the windowed frame time average block
// a result becomes valid after its input beat passes the queue and the read, update,
//   divide, quotient and digit states of the back end; the divider gives one quotient bit per cycle
// the back end takes no new item until its last result has been taken
// the two entry queue keeps taking input beats while a result waits, until it is full
// reset: synchronous active low; clears sum, index, fill count and queue, and loads
//   the clamp ceiling with 100
module windowed_frame_time_average
    import wfta_pkg::*;
#(
    parameter int WINDOW = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [SAMPLE_W-1:0]    i_cfg_data,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [SAMPLE_W-1:0]    i_s_tdata,   // delta_ms
    input  logic                   i_s_tuser,   // restart
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata    // avg_tenths, whole_ms, tenth_digit, fill_count
);

    logic        w_push;
    logic        w_pop;
    t_item       w_front_item;
    t_item       w_queue_item;
    t_queue_stat w_stat;

    // accept and clamp
    wfta_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_push      (w_push),
        .o_item      (w_front_item),
        .i_stat      (w_stat)
    );

    // decoupling queue
    wfta_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_item  (w_queue_item),
        .o_stat  (w_stat)
    );

    // window update and average
    wfta_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (w_queue_item),
        .i_stat     (w_stat),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule
